[rtl/lga_pkg.sv]
// Package: shared constants, types and the arctangent table for landmark association.
package lga_pkg;

    localparam int ANGLE_W = 21;
    localparam logic signed [ANGLE_W-1:0] Q16_PI      = 21'sd205887;
    localparam logic signed [ANGLE_W-1:0] Q16_HALF_PI = 21'sd102944;
    localparam logic signed [ANGLE_W-1:0] Q16_TWO_PI  = 21'sd411775;
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    // Sequencer state codes.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WRAP = 3'd1;
    localparam logic [2:0] ST_ROT  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_SCAN = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    // Configuration register indexes.
    localparam logic [0:0] REG_GATE_RADIUS = 1'd0;
    localparam logic [0:0] REG_MAPPING     = 1'd1;

    typedef logic signed [31:0] coord_t;

    // Arctangent of 2^-i in Q16.
    function automatic logic [16:0] atan_q16(input logic [4:0] i);
        logic [16:0] v;
        begin
            case (i)
                5'd0:  v = 17'd51472;
                5'd1:  v = 17'd30386;
                5'd2:  v = 17'd16055;
                5'd3:  v = 17'd8150;
                5'd4:  v = 17'd4091;
                5'd5:  v = 17'd2047;
                5'd6:  v = 17'd1024;
                5'd7:  v = 17'd512;
                5'd8:  v = 17'd256;
                5'd9:  v = 17'd128;
                5'd10: v = 17'd64;
                5'd11: v = 17'd32;
                5'd12: v = 17'd16;
                5'd13: v = 17'd8;
                5'd14: v = 17'd4;
                5'd15: v = 17'd2;
                5'd16: v = 17'd1;
                default: v = 17'd0;
            endcase
            return v;
        end
    endfunction

endpackage

[rtl/lga_ram.sv]
// Generic single-port RAM with registered read.
module lga_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read at one address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[rtl/lga_cordic.sv]
// Iterative CORDIC rotation: one micro-rotation per cycle, returns Q30 cos and sin.
module lga_cordic #(
    parameter int STEPS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic signed [lga_pkg::ANGLE_W-1:0] angle,
    output logic                          done,
    output logic signed [31:0]            cos_q30,
    output logic signed [31:0]            sin_q30
);
    import lga_pkg::*;

    localparam int CW = $clog2(STEPS + 1);

    logic signed [33:0] x_reg, y_reg;
    logic signed [ANGLE_W:0] z_reg;
    logic [CW-1:0] step_reg;
    logic busy_reg, wrap_reg, neg_reg;
    logic signed [33:0] dx, dy;
    logic signed [ANGLE_W:0] at;
    logic [4:0] step5;

    assign step5 = 5'(step_reg);
    assign dx = y_reg >>> step_reg;
    assign dy = x_reg >>> step_reg;
    assign at = signed'({{(ANGLE_W-16){1'b0}}, atan_q16(step5)});

    // Angle reduction, one turn per cycle, then the rotation steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            wrap_reg <= 1'b0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (go)
            begin
                wrap_reg <= 1'b1;
                z_reg    <= {angle[ANGLE_W-1], angle};
            end
            else if (wrap_reg)
            begin
                // The sum of two inputs can lie several turns out: wrap until in range.
                if (z_reg > 22'(Q16_PI))
                    z_reg <= z_reg - 22'(Q16_TWO_PI);
                else if (z_reg < -22'(Q16_PI))
                    z_reg <= z_reg + 22'(Q16_TWO_PI);
                else
                begin
                    wrap_reg <= 1'b0;
                    busy_reg <= 1'b1;
                    step_reg <= '0;
                    x_reg    <= 34'(CORDIC_GAIN_Q30);
                    y_reg    <= '0;
                    // Fold into the right half plane; this negates cos and sin.
                    if (z_reg > 22'(Q16_HALF_PI))
                    begin
                        z_reg   <= z_reg - 22'(Q16_PI);
                        neg_reg <= 1'b1;
                    end
                    else if (z_reg < -22'(Q16_HALF_PI))
                    begin
                        z_reg   <= z_reg + 22'(Q16_PI);
                        neg_reg <= 1'b1;
                    end
                    else
                    begin
                        neg_reg <= 1'b0;
                    end
                end
            end
            else if (busy_reg)
            begin
                if (step_reg == CW'(STEPS))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
                else
                begin
                    if (!z_reg[ANGLE_W])
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - at;
                    end
                    else
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + at;
                    end
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    assign cos_q30 = neg_reg ? -x_reg[31:0] : x_reg[31:0];
    assign sin_q30 = neg_reg ? -y_reg[31:0] : y_reg[31:0];
endmodule

[rtl/landmark_gated_association.sv]
// Top level: nearest-neighbor landmark association with gated search and mapping.
//
//  channel   ports                                         direction
//  command   start, busy, pose_x..last_of_frame            in; busy out
//  result    done, matched..world_y                        out
//  config    cfg_we, cfg_index, cfg_data                   in
//
// A word passes from the accepting edge through angle wrapping (one turn per step,
// up to three extra turns), the CORDIC steps, ST_MUL, ST_ADD and the table scan
// (read, square x, square y for each searchable entry) to the result strobe; the
// single table RAM port sets the scan rate. busy is high from the accepting edge
// until done; the result shows for one cycle. Reset clears the counts and restores
// the registers; the table RAM needs no clearing. The receiver cannot stall.
module landmark_gated_association #(
    parameter int MAX_LANDMARKS = 256,
    parameter int CORDIC_STEPS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  pose_x,
    input  logic signed [31:0]  pose_y,
    input  logic signed [19:0]  heading,
    input  logic signed [19:0]  bearing,
    input  logic [23:0]         obs_range,
    input  logic [7:0]          obs_class,
    input  logic                last_of_frame,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [23:0]         cfg_data,
    output logic                done,
    output logic                matched,
    output logic [7:0]          landmark_index,
    output logic                added,
    output logic                table_full,
    output logic signed [31:0]  world_x,
    output logic signed [31:0]  world_y
);
    import lga_pkg::*;

    localparam int AW = $clog2(MAX_LANDMARKS);
    localparam int NW = $clog2(MAX_LANDMARKS + 1);
    localparam int EW = 72;

    logic [23:0] gate_reg;
    logic map_reg;
    logic [NW-1:0] stored_reg, search_reg, scan_reg;
    logic [2:0] state_reg;
    logic [1:0] phase_reg;
    logic signed [31:0] px_reg, py_reg, wx_reg, wy_reg;
    logic [23:0] r_reg;
    logic [7:0] cls_reg;
    logic last_reg, matched_reg;
    logic [AW-1:0] best_reg;
    logic [63:0] best_d_reg;
    logic signed [56:0] ox_reg, oy_reg;
    logic [63:0] sq_reg;

    // CORDIC unit.
    logic cgo, cdone;
    logic signed [31:0] cs, sn;
    logic signed [ANGLE_W-1:0] ang;
    assign ang = ANGLE_W'(heading) + ANGLE_W'(bearing);
    assign cgo = start && !busy;

    lga_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .go(cgo), .angle(ang),
        .done(cdone), .cos_q30(cs), .sin_q30(sn)
    );

    // Table RAM: one entry holds x, y and class.
    logic we;
    logic [AW-1:0] addr;
    logic [EW-1:0] wdata, rdata;
    assign wdata = {cls_reg, wy_reg, wx_reg};

    lga_ram #(.WIDTH(EW), .DEPTH(MAX_LANDMARKS)) u_table (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    // Shared subtract-and-square unit for the scan.
    logic signed [32:0] diff;
    logic [32:0] adiff;
    logic [63:0] sq_now, dsum;
    logic [64:0] dsum_full;
    assign diff = (phase_reg == 2'd1)
        ? 33'(wx_reg) - 33'(signed'(rdata[31:0]))
        : 33'(wy_reg) - 33'(signed'(rdata[63:32]));
    assign adiff = diff[32] ? 33'(-diff) : 33'(diff);
    assign sq_now = 64'(adiff[31:0] * adiff[31:0]) + (adiff[32] ? 64'h1 << 64'd63 : 64'd0);
    assign dsum_full = 65'(sq_reg) + 65'(sq_now);
    assign dsum = dsum_full[64] ? '1 : dsum_full[63:0];

    // Saturating add of the rounded offset to the pose.
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                   input logic signed [56:0] o);
        logic signed [57:0] s;
        begin
            s = 58'(p) + 58'(o);
            if (s > 58'sd2147483647)
                return 32'sh7fffffff;
            else if (s < -58'sd2147483648)
                return 32'sh80000000;
            else
                return s[31:0];
        end
    endfunction

    logic add_ok;
    assign add_ok = !matched_reg && map_reg && (stored_reg < NW'(MAX_LANDMARKS));
    assign we = (state_reg == ST_DONE) && add_ok;
    assign addr = (state_reg == ST_DONE) ? stored_reg[AW-1:0] : scan_reg[AW-1:0];
    assign busy = (state_reg != ST_IDLE);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg <= 24'd124518;
            map_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GATE_RADIUS: gate_reg <= cfg_data;
                REG_MAPPING:     map_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            stored_reg <= '0;
            search_reg <= '0;
            done       <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        px_reg   <= pose_x;
                        py_reg   <= pose_y;
                        r_reg    <= obs_range;
                        cls_reg  <= obs_class;
                        last_reg <= last_of_frame;
                        state_reg <= ST_WRAP;
                    end
                end
                ST_WRAP:
                begin
                    if (cdone)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    ox_reg <= 57'(signed'({1'b0, r_reg}) * cs);
                    oy_reg <= 57'(signed'({1'b0, r_reg}) * sn);
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    wx_reg <= sat_add(px_reg, (ox_reg + 57'sd536870912) >>> 30);
                    wy_reg <= sat_add(py_reg, (oy_reg + 57'sd536870912) >>> 30);
                    best_d_reg  <= 64'(gate_reg * gate_reg);
                    matched_reg <= 1'b0;
                    scan_reg    <= '0;
                    phase_reg   <= 2'd0;
                    state_reg   <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    // Phase 0 reads, 1 squares x, 2 squares y and compares.
                    if (phase_reg == 2'd0)
                    begin
                        if (scan_reg >= search_reg)
                            state_reg <= ST_DONE;
                        else
                            phase_reg <= 2'd1;
                    end
                    else if (phase_reg == 2'd1)
                    begin
                        sq_reg    <= sq_now;
                        phase_reg <= 2'd2;
                    end
                    else
                    begin
                        if (rdata[71:64] == cls_reg && dsum < best_d_reg)
                        begin
                            best_d_reg  <= dsum;
                            best_reg    <= scan_reg[AW-1:0];
                            matched_reg <= 1'b1;
                        end
                        scan_reg  <= scan_reg + 1'b1;
                        phase_reg <= 2'd0;
                    end
                end
                ST_DONE:
                begin
                    done           <= 1'b1;
                    matched        <= matched_reg;
                    world_x        <= wx_reg;
                    world_y        <= wy_reg;
                    added          <= add_ok;
                    table_full     <= !matched_reg && map_reg && !add_ok;
                    landmark_index <= matched_reg ? 8'(best_reg)
                                    : (add_ok ? 8'(stored_reg) : 8'd0);
                    if (add_ok)
                    begin
                        stored_reg <= stored_reg + 1'b1;
                    end
                    if (last_reg)
                    begin
                        search_reg <= add_ok ? stored_reg + 1'b1 : stored_reg;
                    end
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

[tb/tb_landmark_gated_association.sv]
// Testbench for landmark_gated_association: directed and random observations checked by a predictor.
`timescale 1ns / 1ps

module tb_landmark_gated_association;
    import lga_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int ROT_STEPS = 16;
    localparam longint CYCLE_LIMIT = 5000000;
    localparam int ATAN_Q16 [0:15] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                       256, 128, 64, 32, 16, 8, 4, 2};

    typedef struct packed {
        logic        matched;
        logic [7:0]  landmark_index;
        logic        added;
        logic        table_full;
        logic [31:0] world_x;
        logic [31:0] world_y;
    } assoc_t;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [19:0] hd;
        logic signed [19:0] br;
        logic [23:0]        rng;
        logic [7:0]         cls;
        logic               last;
        logic               typed;
        assoc_t             want;
    } obs_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [19:0] heading;
    logic signed [19:0] bearing;
    logic [23:0] obs_range;
    logic [7:0] obs_class;
    logic last_of_frame;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [23:0] cfg_data;
    logic done;
    logic matched;
    logic [7:0] landmark_index;
    logic added;
    logic table_full;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;

    // Predictor copy of the block's registers and landmark table.
    logic [23:0] gate_q;
    logic mapping_q;
    logic signed [31:0] map_x [TABLE_DEPTH];
    logic signed [31:0] map_y [TABLE_DEPTH];
    logic [7:0] map_cls [TABLE_DEPTH];
    int stored_n;
    int search_n;

    assoc_t pending_q [$];
    int fail_count;
    int match_count;
    int add_count;
    int full_count;
    int word_count;
    longint cycle_count;
    bit quiet;

    landmark_gated_association DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pose_x(pose_x), .pose_y(pose_y), .heading(heading), .bearing(bearing),
        .obs_range(obs_range), .obs_class(obs_class), .last_of_frame(last_of_frame),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .matched(matched), .landmark_index(landmark_index),
        .added(added), .table_full(table_full), .world_x(world_x), .world_y(world_y)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Overall watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint unsigned square_mag(input longint d);
        longint unsigned a;
        a = (d < 0) ? longint'(-d) : d;
        return a * a;
    endfunction

    // Project the observation, scan the searchable table and update the map.
    function automatic assoc_t associate(input obs_row_t o);
        assoc_t res;
        longint ang, cx, cy, z, dx, dy, r;
        longint unsigned gate_sq, best_d, sx, sy, d;
        bit flip;
        int best;
        res = '0;
        flip = 1'b0;
        ang = longint'(o.hd) + longint'(o.br);
        while (ang > 205887)
            ang -= 411775;
        while (ang < -205887)
            ang += 411775;
        if (ang > 102944)
        begin
            ang -= 205887;
            flip = 1'b1;
        end
        else if (ang < -102944)
        begin
            ang += 205887;
            flip = 1'b1;
        end
        cx = 652032874;
        cy = 0;
        z = ang;
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0)
            begin
                cx -= dx;
                cy += dy;
                z -= ATAN_Q16[i];
            end
            else
            begin
                cx += dx;
                cy -= dy;
                z += ATAN_Q16[i];
            end
        end
        if (flip)
        begin
            cx = -cx;
            cy = -cy;
        end
        r = longint'(o.rng);
        res.world_x = clamp32(longint'(o.px) + ((r * cx + (64'sd1 <<< 29)) >>> 30));
        res.world_y = clamp32(longint'(o.py) + ((r * cy + (64'sd1 <<< 29)) >>> 30));

        gate_sq = longint'(gate_q) * longint'(gate_q);
        best_d = gate_sq;
        best = 0;
        for (int i = 0; i < search_n; i++)
        begin
            if (map_cls[i] == o.cls)
            begin
                sx = square_mag(longint'($signed(res.world_x)) - longint'(map_x[i]));
                sy = square_mag(longint'($signed(res.world_y)) - longint'(map_y[i]));
                d = sx + sy;
                if (d < sx)
                    d = '1;
                if (d < best_d)
                begin
                    best_d = d;
                    best = i;
                    res.matched = 1'b1;
                end
            end
        end

        if (res.matched)
            res.landmark_index = best[7:0];
        else if (mapping_q)
        begin
            if (stored_n < TABLE_DEPTH)
            begin
                map_x[stored_n] = res.world_x;
                map_y[stored_n] = res.world_y;
                map_cls[stored_n] = o.cls;
                res.landmark_index = stored_n[7:0];
                stored_n++;
                res.added = 1'b1;
            end
            else
                res.table_full = 1'b1;
        end
        if (o.last)
            search_n = stored_n;
        return res;
    endfunction

    // Result checker: every done word is compared with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result word with no expectation waiting");
                fail_count++;
            end
            else
            begin
                assoc_t e;
                e = pending_q.pop_front();
                if (matched !== e.matched)
                begin
                    $error("matched: expected %0d actual %0d", e.matched, matched);
                    fail_count++;
                end
                if (landmark_index !== e.landmark_index)
                begin
                    $error("landmark_index: expected %0d actual %0d",
                           e.landmark_index, landmark_index);
                    fail_count++;
                end
                if (added !== e.added)
                begin
                    $error("added: expected %0d actual %0d", e.added, added);
                    fail_count++;
                end
                if (table_full !== e.table_full)
                begin
                    $error("table_full: expected %0d actual %0d", e.table_full, table_full);
                    fail_count++;
                end
                if (world_x !== e.world_x)
                begin
                    $error("world_x: expected %h actual %h", e.world_x, world_x);
                    fail_count++;
                end
                if (world_y !== e.world_y)
                begin
                    $error("world_y: expected %h actual %h", e.world_y, world_y);
                    fail_count++;
                end
                match_count += e.matched;
                add_count += e.added;
                full_count += e.table_full;
            end
        end
    end

    // Drive one observation word from a falling edge and wait for it to be taken.
    task automatic send_obs(input obs_row_t o);
        assoc_t pred;
        pose_x = o.px;
        pose_y = o.py;
        heading = o.hd;
        bearing = o.br;
        obs_range = o.rng;
        obs_class = o.cls;
        last_of_frame = o.last;
        start = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pred = associate(o);
        pending_q = {pending_q, (o.typed ? o.want : pred)};
        word_count++;
        @(negedge clk);
        start = 1'b0;
        if (!quiet && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) @(negedge clk);
    endtask

    // Wait until every expected word has arrived, plus a short settle.
    task automatic drain();
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [23:0] val);
        drain();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_GATE_RADIUS)
            gate_q = val;
        else
            mapping_q = val[0];
    endtask

    // Well-formed observations cluster near the origin so that matches occur.
    function automatic obs_row_t rand_obs(input bit noisy);
        obs_row_t o;
        o.typed = 1'b0;
        o.want = '0;
        o.last = ($urandom_range(0, 3) == 0);
        if (noisy)
        begin
            o.px = $urandom;
            o.py = $urandom;
            o.hd = 20'($urandom);
            o.br = 20'($urandom);
            o.rng = 24'($urandom);
            o.cls = 8'($urandom);
        end
        else
        begin
            o.px = $urandom_range(0, 393216) - 196608;
            o.py = $urandom_range(0, 393216) - 196608;
            o.hd = 20'($urandom);
            o.br = 20'($urandom_range(0, 205887) - 102944);
            o.rng = 24'($urandom_range(0, 262144));
            o.cls = 8'($urandom_range(0, 3));
        end
        return o;
    endfunction

    task automatic random_phase(input int count, input bit toggle_map);
        for (int n = 0; n < count; n++)
        begin
            if (toggle_map && $urandom_range(0, 40) == 0)
                write_reg(REG_MAPPING, {23'd0, 1'($urandom)});
            send_obs(rand_obs($urandom_range(0, 3) == 0));
        end
    endtask

    obs_row_t dir_rows [$];

    task automatic add_row(input logic signed [31:0] px, input logic signed [31:0] py,
                           input logic signed [19:0] hd, input logic signed [19:0] br,
                           input logic [23:0] rng, input logic [7:0] cls, input logic last,
                           input logic typed, input assoc_t want);
        obs_row_t o;
        o.px = px;
        o.py = py;
        o.hd = hd;
        o.br = br;
        o.rng = rng;
        o.cls = cls;
        o.last = last;
        o.typed = typed;
        o.want = want;
        dir_rows = {dir_rows, o};
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        pose_x = '0;
        pose_y = '0;
        heading = '0;
        bearing = '0;
        obs_range = '0;
        obs_class = '0;
        last_of_frame = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_GATE_RADIUS;
        cfg_data = '0;
        gate_q = 24'd124518;
        mapping_q = 1'b1;
        stored_n = 0;
        search_n = 0;
        fail_count = 0;
        match_count = 0;
        add_count = 0;
        full_count = 0;
        word_count = 0;
        cycle_count = 0;
        quiet = 1'b0;

        // Directed rows: zero range, first add, match, extreme poses and angles.
        add_row(32'sd5, 32'sd7, 20'sd0, 20'sd0, 24'd0, 8'd1, 1'b1, 1'b1,
                '{1'b0, 8'd0, 1'b1, 1'b0, 32'd5, 32'd7});
        add_row(32'sd5, 32'sd7, 20'sd0, 20'sd0, 24'd0, 8'd1, 1'b0, 1'b1,
                '{1'b1, 8'd0, 1'b0, 1'b0, 32'd5, 32'd7});
        add_row(32'sh7fffffff, 32'sd0, 20'sd0, 20'sd0, 24'd0, 8'd255, 1'b0, 1'b1,
                '{1'b0, 8'd1, 1'b1, 1'b0, 32'h7fffffff, 32'd0});
        add_row(32'sh80000000, 32'sh80000000, 20'sd0, 20'sd0, 24'd0, 8'd255, 1'b1, 1'b1,
                '{1'b0, 8'd2, 1'b1, 1'b0, 32'h80000000, 32'h80000000});
        add_row(32'sh7fffffff, 32'sh7fffffff, 20'sd0, 20'sd0, 24'hffffff, 8'd0, 1'b0, 1'b0, '0);
        add_row(32'sh80000000, 32'sh80000000, 20'sh7ffff, 20'sh7ffff, 24'hffffff, 8'd0,
                1'b0, 1'b0, '0);
        add_row(32'sd0, 32'sd0, 20'sh80000, 20'sh80000, 24'hffffff, 8'd3, 1'b0, 1'b0, '0);
        add_row(32'sd0, 32'sd0, 20'sd102944, 20'sd1, 24'd65536, 8'd3, 1'b0, 1'b0, '0);
        add_row(32'sd0, 32'sd0, -20'sd102944, -20'sd1, 24'd65536, 8'd3, 1'b0, 1'b0, '0);
        add_row(32'sd0, 32'sd0, 20'sd205887, 20'sd1, 24'd65536, 8'd3, 1'b0, 1'b0, '0);
        add_row(32'sd0, 32'sd0, -20'sd205887, -20'sd1, 24'd65536, 8'd3, 1'b1, 1'b0, '0);
        add_row(32'sd0, 32'sd0, 20'sd102944, 20'sd0, 24'd65536, 8'd3, 1'b0, 1'b0, '0);
        add_row(32'sd1000, 32'sd0, 20'sd0, 20'sd0, 24'd65536, 8'd3, 1'b0, 1'b0, '0);
        add_row(32'sd0, 32'sd1000, 20'sd0, 20'sd0, 24'd65536, 8'd3, 1'b1, 1'b0, '0);
        add_row(32'sd0, 32'sd0, 20'sd0, 20'sd0, 24'd65536, 8'd3, 1'b1, 1'b0, '0);
        add_row(32'sh55555555, 32'shaaaaaaaa, 20'sh55555, 20'shaaaaa, 24'h555555, 8'h55,
                1'b0, 1'b0, '0);
        add_row(32'shaaaaaaaa, 32'sh55555555, 20'shaaaaa, 20'sh55555, 24'haaaaaa, 8'haa,
                1'b1, 1'b0, '0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[k])
            send_obs(dir_rows[k]);

        // Mapping off: unmatched words are discarded.
        write_reg(REG_MAPPING, 24'd0);
        add_row(32'sd900000, 32'sd900000, 20'sd0, 20'sd0, 24'd0, 8'd9, 1'b1, 1'b1,
                '{1'b0, 8'd0, 1'b0, 1'b0, 32'd900000, 32'd900000});
        send_obs(dir_rows[dir_rows.size() - 1]);
        write_reg(REG_MAPPING, 24'd1);

        // Random phases over several register settings.
        random_phase(420, 1'b0);
        write_reg(REG_GATE_RADIUS, 24'd0);
        random_phase(300, 1'b0);
        write_reg(REG_GATE_RADIUS, 24'hffffff);
        random_phase(300, 1'b0);
        write_reg(REG_MAPPING, 24'd0);
        write_reg(REG_GATE_RADIUS, 24'd32768);
        random_phase(300, 1'b1);
        write_reg(REG_GATE_RADIUS, 24'($urandom_range(0, 400000)));
        write_reg(REG_MAPPING, 24'd1);
        random_phase(250, 1'b1);
        quiet = 1'b1;
        random_phase(230, 1'b0);

        drain();
        repeat (40) @(negedge clk);
        $display("Ran %0d observation words: %0d matched, %0d added, %0d refused as full.",
                 word_count, match_count, add_count, full_count);
        $display("Gate settings covered zero, default, mid and maximum; mapping on and off.");
        if (fail_count == 0 && pending_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
